// File: hdl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Shared widths, register indexes, defaults and the search token type for the
// slotted-page first-fit allocator.
// ----------------------------------------------------------------------------
package spf_pkg;

    // field widths
    localparam int DATA_W    = 16;   // byte offsets, lengths, block size
    localparam int PAGE_W    = 8;    // page index in a result
    localparam int SLOT_W    = 13;   // slot index in a result
    localparam int CNT_W     = 9;    // page count register
    localparam int CFG_IDX_W = 1;    // configuration register index
    localparam int CFG_W     = 16;   // configuration write data

    // parameter defaults
    localparam int MAX_PAGES_DEF    = 256;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int SLOT_BYTES_DEF   = 8;

    // register reset values
    localparam logic [DATA_W-1:0] BLOCK_SIZE_RST = 16'd4096;
    localparam logic [CNT_W-1:0]  PAGE_COUNT_RST = 9'd256;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'b1;

    // search token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              placed;
        logic [DATA_W-1:0] len;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] slot_off;
        logic [DATA_W-1:0] data_off;
    } token_t;

endpackage

// File: hdl/spf_if.sv
// ----------------------------------------------------------------------------
// spf_if
// Valid/ready channels: insert requests and allocation results.
// ----------------------------------------------------------------------------
interface spf_req_if;
    logic                       valid;
    logic                       ready;
    logic [spf_pkg::DATA_W-1:0] data_len;

    modport source (output valid, output data_len, input ready);
    modport sink   (input valid, input data_len, output ready);
endinterface

interface spf_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       status;
    logic [spf_pkg::PAGE_W-1:0] page_index;
    logic [spf_pkg::SLOT_W-1:0] slot_index;
    logic [spf_pkg::DATA_W-1:0] slot_offset;
    logic [spf_pkg::DATA_W-1:0] data_offset;

    modport source (output valid, output status, output page_index, output slot_index,
                    output slot_offset, output data_offset, input ready);
    modport sink   (input valid, input status, input page_index, input slot_index,
                    input slot_offset, input data_offset, output ready);
endinterface

// File: hdl/slotted_page_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// slotted_page_first_fit_allocator
// First-fit record placement over a chain of page cells.
// The search token moves one page cell per cycle through the registered cells
// and then into the result register, so every item walks the whole chain.
// Only one item is in flight; a new request is taken once the previous result
// has been delivered.
// Reset: pages empty, block size 4096, page count 256, no item in flight.
// ----------------------------------------------------------------------------
module slotted_page_first_fit_allocator #(
    parameter int MAX_PAGES    = spf_pkg::MAX_PAGES_DEF,
    parameter int HEADER_BYTES = spf_pkg::HEADER_BYTES_DEF,
    parameter int SLOT_BYTES   = spf_pkg::SLOT_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    spf_req_if.sink                       req,
    spf_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [spf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spf_pkg::CFG_W-1:0]     cfg_data
);

    localparam int IDX_W   = $clog2(MAX_PAGES + 1);
    localparam int LIMIT_W = (IDX_W > spf_pkg::CNT_W) ? IDX_W : spf_pkg::CNT_W;

    logic [spf_pkg::CNT_W-1:0]  page_count_reg;
    logic                       busy_reg;
    logic                       out_valid_reg;
    spf_pkg::token_t            out_tok_reg;

    logic                 format;
    logic [LIMIT_W-1:0]   count_ext;
    logic [LIMIT_W-1:0]   limit;
    logic                 in_acc;
    logic                 out_acc;
    spf_pkg::token_t      tok [MAX_PAGES+1];

    // configuration; a block size write reformats every page cell directly
    assign format = cfg_we && (cfg_index == spf_pkg::CFG_BLOCK_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_count_reg <= spf_pkg::PAGE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spf_pkg::CFG_PAGE_COUNT: page_count_reg <= cfg_data[spf_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // pages searched, clamped to the chain length
    assign count_ext = LIMIT_W'(page_count_reg);
    assign limit     = (count_ext > LIMIT_W'(MAX_PAGES)) ? LIMIT_W'(MAX_PAGES) : count_ext;

    // handshakes
    assign req.ready = !busy_reg;
    assign in_acc    = req.valid && !busy_reg;
    assign out_acc   = out_valid_reg && rsp.ready;

    // launch token
    always_comb
    begin
        tok[0]          = '0;
        tok[0].valid    = in_acc;
        tok[0].len      = req.data_len;
    end

    // chain of page cells
    for (genvar i = 0; i < MAX_PAGES; i++)
    begin : g_cell
        spf_cell #(
            .HEADER_BYTES (HEADER_BYTES),
            .SLOT_BYTES   (SLOT_BYTES),
            .CELL_IDX     (i),
            .LIMIT_W      (LIMIT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .format     (format),
            .block_size (cfg_data[spf_pkg::DATA_W-1:0]),
            .limit      (limit),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1])
        );
    end

    // item tracking and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                busy_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                busy_reg <= 1'b0;
            end

            if (tok[MAX_PAGES].valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok[MAX_PAGES].valid)
        begin
            out_tok_reg <= tok[MAX_PAGES];
        end
    end

    // result fields; a full store reports zeros from the untouched token
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = !out_tok_reg.placed;
    assign rsp.page_index  = out_tok_reg.page;
    assign rsp.slot_index  = out_tok_reg.slot;
    assign rsp.slot_offset = out_tok_reg.slot_off;
    assign rsp.data_offset = out_tok_reg.data_off;

endmodule

// File: hdl/spf_cell.sv
// ----------------------------------------------------------------------------
// spf_cell
// One page of the store: slot directory end, data start and slot count.
// Tests the passing search token for a fit, claims it, and forwards it.
// ----------------------------------------------------------------------------
module spf_cell #(
    parameter int HEADER_BYTES = spf_pkg::HEADER_BYTES_DEF,
    parameter int SLOT_BYTES   = spf_pkg::SLOT_BYTES_DEF,
    parameter int CELL_IDX     = 0,
    parameter int LIMIT_W      = spf_pkg::CNT_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       format,
    input  logic [spf_pkg::DATA_W-1:0] block_size,
    input  logic [LIMIT_W-1:0]         limit,
    input  spf_pkg::token_t            tok_in,
    output spf_pkg::token_t            tok_out
);

    localparam int SUM_W = spf_pkg::DATA_W + 2;

    logic [spf_pkg::DATA_W-1:0] slot_end_reg;
    logic [spf_pkg::DATA_W-1:0] data_start_reg;
    logic [spf_pkg::SLOT_W-1:0] slot_cnt_reg;
    spf_pkg::token_t            tok_reg;
    spf_pkg::token_t            tok_next;

    logic             in_range;
    logic [SUM_W-1:0] need;
    logic             fit;

    // fit test, computed without wrap
    assign in_range = LIMIT_W'(CELL_IDX) < limit;
    assign need     = SUM_W'(slot_end_reg) + SUM_W'(SLOT_BYTES) + SUM_W'(tok_in.len);
    assign fit      = tok_in.valid && !tok_in.placed && in_range
                      && (need <= SUM_W'(data_start_reg));

    // claim the token on a fit
    always_comb
    begin
        tok_next = tok_in;
        if (fit)
        begin
            tok_next.placed   = 1'b1;
            tok_next.page     = spf_pkg::PAGE_W'(CELL_IDX);
            tok_next.slot     = slot_cnt_reg;
            tok_next.slot_off = slot_end_reg;
            tok_next.data_off = data_start_reg - tok_in.len;
        end
    end

    // page pointers; format restores an empty page
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_end_reg   <= spf_pkg::DATA_W'(HEADER_BYTES);
            data_start_reg <= spf_pkg::BLOCK_SIZE_RST;
            slot_cnt_reg   <= '0;
        end
        else if (format)
        begin
            slot_end_reg   <= spf_pkg::DATA_W'(HEADER_BYTES);
            data_start_reg <= block_size;
            slot_cnt_reg   <= '0;
        end
        else if (fit)
        begin
            slot_end_reg   <= slot_end_reg + spf_pkg::DATA_W'(SLOT_BYTES);
            data_start_reg <= data_start_reg - tok_in.len;
            slot_cnt_reg   <= slot_cnt_reg + spf_pkg::SLOT_W'(1);
        end
    end

    // token stage to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg.valid <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the slotted-page first-fit allocator. A queue-fed
// driver offers record lengths on the request channel. A predictor keeps its
// own per-page directory and payload pointers and computes the placement of
// every accepted item. A monitor checks each result, field by field, against
// the oldest prediction. Directed corner items come first, then randomized
// phases under several page geometries and several idle patterns.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_PAGES    = spf_pkg::MAX_PAGES_DEF;
    localparam int HEADER_BYTES = spf_pkg::HEADER_BYTES_DEF;
    localparam int SLOT_BYTES   = spf_pkg::SLOT_BYTES_DEF;

    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 108;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = MAX_PAGES + 16;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef enum logic [1:0] {
        GAPS_RECV_HEAVY,    // sender idles lightly, receiver heavily
        GAPS_SEND_HEAVY,    // sender idles heavily, receiver lightly
        GAPS_NONE           // neither side idles at random
    } gap_mode_t;

    // one placement outcome
    typedef struct packed {
        logic                       status;
        logic [spf_pkg::PAGE_W-1:0] page;
        logic [spf_pkg::SLOT_W-1:0] slot;
        logic [spf_pkg::DATA_W-1:0] slot_off;
        logic [spf_pkg::DATA_W-1:0] data_off;
    } alloc_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [spf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [spf_pkg::CFG_W-1:0]     cfg_data;

    spf_req_if req_ch ();
    spf_rsp_if rsp_ch ();

    slotted_page_first_fit_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state: per-page pointers and register copies
    logic [spf_pkg::DATA_W-1:0] page_lo [MAX_PAGES];
    logic [spf_pkg::DATA_W-1:0] page_hi [MAX_PAGES];
    logic [spf_pkg::DATA_W-1:0] reg_block_size;
    logic [spf_pkg::CNT_W-1:0]  reg_page_count;

    logic [spf_pkg::DATA_W-1:0] pending_lens [$];
    alloc_t                     expected_allocs [$];

    int unsigned       queued_total;
    int unsigned       accepted_total;
    int unsigned       checked_total;
    int unsigned       err_count;
    int unsigned       cycles;
    int unsigned       hold_left;
    bit                hold_used;
    gap_mode_t         gap_mode = GAPS_RECV_HEAVY;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        err_count++;
    endtask

    // idle percentage for one side under the current pattern
    function automatic int unsigned gap_pct(input gap_mode_t m, input bit sender);
        case (m)
            GAPS_RECV_HEAVY: return sender ? 15 : 48;
            GAPS_SEND_HEAVY: return sender ? 48 : 15;
            default:         return 0;
        endcase
    endfunction

    // every page back to empty with the current block size
    function automatic void format_pages();
        for (int p = 0; p < MAX_PAGES; p++)
        begin
            page_lo[p] = spf_pkg::DATA_W'(HEADER_BYTES);
            page_hi[p] = reg_block_size;
        end
    endfunction

    // first-fit placement of one record; moves the pointers of the chosen page
    function automatic alloc_t place_record(input logic [spf_pkg::DATA_W-1:0] len);
        alloc_t      res;
        int unsigned limit;
        int unsigned lo;
        int unsigned hi;
        bit          found;
        res   = '0;
        res.status = 1'b1;
        found = 1'b0;
        limit = (reg_page_count > MAX_PAGES) ? MAX_PAGES : reg_page_count;
        for (int p = 0; p < limit; p++)
        begin
            lo = page_lo[p];
            hi = page_hi[p];
            if (!found && lo + SLOT_BYTES + len <= hi)
            begin
                found        = 1'b1;
                res.status   = 1'b0;
                res.page     = spf_pkg::PAGE_W'(p);
                res.slot     = spf_pkg::SLOT_W'((lo >= HEADER_BYTES) ?
                                                (lo - HEADER_BYTES) / SLOT_BYTES : 0);
                res.slot_off = spf_pkg::DATA_W'(lo);
                res.data_off = spf_pkg::DATA_W'(hi - len);
                page_lo[p]   = spf_pkg::DATA_W'(lo + SLOT_BYTES);
                page_hi[p]   = spf_pkg::DATA_W'(hi - len);
            end
        end
        return res;
    endfunction

    // predictor: register writes and accepted requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_block_size = spf_pkg::BLOCK_SIZE_RST;
            reg_page_count = spf_pkg::PAGE_COUNT_RST;
            format_pages();
            accepted_total <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == spf_pkg::CFG_BLOCK_SIZE)
                begin
                    reg_block_size = cfg_data[spf_pkg::DATA_W-1:0];
                    format_pages();
                end
                else if (cfg_index == spf_pkg::CFG_PAGE_COUNT)
                    reg_page_count = cfg_data[spf_pkg::CNT_W-1:0];
            end
            if (req_ch.valid && req_ch.ready)
            begin
                expected_allocs.push_back(place_record(req_ch.data_len));
                accepted_total <= accepted_total + 1;
            end
        end
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.data_len <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_lens.size() != 0 && $urandom_range(99) >= gap_pct(gap_mode, 1'b1))
            begin
                req_ch.valid    <= 1'b1;
                req_ch.data_len <= pending_lens.pop_front();
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // long receiver hold-off, once, while the sender keeps offering
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_used && gap_mode == GAPS_NONE && pending_lens.size() > 20)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // result ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= (hold_left == 0) &&
                            ($urandom_range(99) >= gap_pct(gap_mode, 1'b0));
    end

    // result monitor
    always @(posedge clk)
    begin
        alloc_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_allocs.size() == 0)
                report_mismatch($sformatf("result %0d with no item outstanding",
                                          checked_total));
            else
            begin
                want = expected_allocs.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("result %0d: status got %0d want %0d",
                                              checked_total, rsp_ch.status, want.status));
                if (rsp_ch.page_index !== want.page)
                    report_mismatch($sformatf("result %0d: page_index got %0d want %0d",
                                              checked_total, rsp_ch.page_index, want.page));
                if (rsp_ch.slot_index !== want.slot)
                    report_mismatch($sformatf("result %0d: slot_index got %0d want %0d",
                                              checked_total, rsp_ch.slot_index, want.slot));
                if (rsp_ch.slot_offset !== want.slot_off)
                    report_mismatch($sformatf("result %0d: slot_offset got %0d want %0d",
                                              checked_total, rsp_ch.slot_offset,
                                              want.slot_off));
                if (rsp_ch.data_offset !== want.data_off)
                    report_mismatch($sformatf("result %0d: data_offset got %0d want %0d",
                                              checked_total, rsp_ch.data_offset,
                                              want.data_off));
            end
            checked_total++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [spf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [spf_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic queue_len(input logic [spf_pkg::DATA_W-1:0] len);
        pending_lens.push_back(len);
        queued_total++;
    endtask

    // wait until every queued item has been answered
    task automatic settle();
        while (accepted_total != queued_total || expected_allocs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int unsigned blk;
        int unsigned pc;
        int unsigned r;
        logic [spf_pkg::DATA_W-1:0] len;
        cycles         = 0;
        err_count      = 0;
        checked_total  = 0;
        queued_total   = 0;
        rst_n          = 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= spf_pkg::CFG_BLOCK_SIZE;
        cfg_data      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: empty record, oversize, exact page fill, one past it
        queue_len(16'd0);
        queue_len(16'd65535);
        queue_len(16'd4080);
        queue_len(16'd4081);
        queue_len(16'd1);
        queue_len(16'd32768);
        settle();

        // smallest page: one empty record per page, then full
        write_reg(spf_pkg::CFG_BLOCK_SIZE, 16'd16);
        write_reg(spf_pkg::CFG_PAGE_COUNT, 16'd2);
        queue_len(16'd0);
        queue_len(16'd0);
        queue_len(16'd0);
        queue_len(16'd1);
        settle();

        // no page searched
        write_reg(spf_pkg::CFG_PAGE_COUNT, 16'd0);
        queue_len(16'd0);
        settle();

        // page too small for header plus slot; count beyond the page array
        write_reg(spf_pkg::CFG_BLOCK_SIZE, 16'd15);
        write_reg(spf_pkg::CFG_PAGE_COUNT, 16'd511);
        queue_len(16'd0);
        settle();

        // largest page: exact fill, one past it, alternating bit patterns
        write_reg(spf_pkg::CFG_BLOCK_SIZE, 16'd65535);
        write_reg(spf_pkg::CFG_PAGE_COUNT, 16'd256);
        queue_len(16'd65519);
        queue_len(16'd65520);
        queue_len(16'd0);
        queue_len(16'h5555);
        queue_len(16'hAAAA);
        settle();

        // shrinking the count keeps the page contents
        write_reg(spf_pkg::CFG_PAGE_COUNT, 16'd1);
        queue_len(16'd0);
        settle();

        // randomized phases; odd phases change the count only
        blk = 65535;
        for (int k = 0; k < RAND_PHASES; k++)
        begin
            @(posedge clk);
            gap_mode <= (k < 4) ? GAPS_RECV_HEAVY : (k < 8) ? GAPS_SEND_HEAVY : GAPS_NONE;
            case (k % 4)
                0:
                begin
                    blk = $urandom_range(16, 400);
                    pc  = $urandom_range(1, 8);
                end
                1: pc = $urandom_range(1, 12);
                2:
                begin
                    r = $urandom_range(3);
                    blk = (r == 0) ? 16 : (r == 1) ? 65535 : $urandom_range(1000, 65535);
                    pc  = $urandom_range(200, 511);
                end
                default: pc = $urandom_range(0, 6);
            endcase
            if (k % 2 == 0)
                write_reg(spf_pkg::CFG_BLOCK_SIZE, spf_pkg::CFG_W'(blk));
            // upper data bits beyond the count width are junk
            write_reg(spf_pkg::CFG_PAGE_COUNT, {7'($urandom_range(127)), 9'(pc)});
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                r = $urandom_range(99);
                if (r < 5)
                    len = spf_pkg::DATA_W'($urandom_range(65535));
                else if (r < 15)
                    len = '0;
                else if (r < 25 && blk >= 19)
                    len = spf_pkg::DATA_W'(blk - 16 - $urandom_range(3));
                else
                    len = spf_pkg::DATA_W'($urandom_range(blk / 3 + 1));
                queue_len(len);
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_allocs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_allocs.size()));
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/spf_pkg.sv
hdl/spf_if.sv
hdl/spf_cell.sv
hdl/slotted_page_first_fit_allocator.sv
tb/sv/tb.sv
